/* design/rbf_pkg.sv */
// Shared types, sizes and helpers for the ring buffer FIFO core.
// No dependencies; imported by the core and its testbench.
package rbf_pkg;

  localparam int DEPTH     = 1024;
  localparam int DATA_W    = 32;
  localparam int MAX_BURST = 16;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int BURST_W   = $clog2(MAX_BURST + 1);
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

  // Step a ring index by one, wrapping at the capacity in use.
  function automatic logic [ADDR_W-1:0] ring_adv(input logic [ADDR_W-1:0] pos,
                                                 input logic [CNT_W-1:0]  cap);
    logic [CNT_W:0] p1;
    p1 = (CNT_W + 1)'(pos) + (CNT_W + 1)'(1);
    return (p1 >= {1'b0, cap}) ? '0 : ADDR_W'(p1);
  endfunction

endpackage

/* design/ring_buffer_fifo_core.sv */
// Ring buffer FIFO core: circular word store with push, pop, peek and bulk delete.
// Depends on rbf_pkg (sizes, opcodes, status codes) and rbf_ram (word storage).
//
// A circular FIFO of 32-bit words held in a 1024-entry synchronous RAM. The
// capacity in use is set through cfg_wr_en/cfg_wr_data (0 is taken as 1, values
// above 1024 as 1024); any write empties the buffer. Each input transfer carries
// one operation in in_tuser: push stores in_tdata's word at the tail (status full
// when no room), pop removes up to count words and emits each, peek emits up to
// count words from the head without removing them, and delete drops up to count
// words and emits one summary result. Pop and peek count saturates at 16; when
// words run out the run ends with an extra result of status empty and tlast set.
// Every result reports done count, fill level and free space after that result.
// Push, delete and zero-count pop or peek give their result as they are taken.
// A pop or peek first issues the RAM read of the head word, then emits one
// result per cycle while the output is not stalled, reading the next word ahead.
// A single output register parts the two sides; a stalled output stalls the run
// and holds off new input transfers. Writing the capacity takes effect at once.
module ring_buffer_fifo_core
  import rbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [CNT_W-1:0]     cfg_wr_data,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,   // [31:0] data_in, [42:32] count, rest zero
  input  logic [OP_W-1:0]      in_tuser,   // [1:0] opcode
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [71:0]          out_tdata,  // [31:0] data_out, [42:32] done_count,
                                           // [53:43] fill_level, [64:54] free_space
  output logic [STATUS_W-1:0]  out_tuser,  // [1:0] status
  output logic                 out_tlast
);

  // Control state
  state_t             state_r,  state_nxt;
  logic [ADDR_W-1:0]  head_r,   head_nxt;
  logic [ADDR_W-1:0]  tail_r,   tail_nxt;
  logic [CNT_W-1:0]   level_r,  level_nxt;
  logic [CNT_W-1:0]   cap_r,    cap_nxt;
  logic [ADDR_W-1:0]  pos_r,    pos_nxt;
  logic [BURST_W-1:0] idx_r,    idx_nxt;
  logic [BURST_W-1:0] nburst_r, nburst_nxt;
  logic               pop_r,    pop_nxt;
  logic               out_valid_r;

  // Output payload
  logic [DATA_W-1:0]  out_data_r;
  status_t            out_status_r;
  logic               out_last_r;
  logic [CNT_W-1:0]   out_done_r;
  logic [CNT_W-1:0]   out_fill_r;
  logic [CNT_W-1:0]   out_free_r;

  // Input fields
  op_t                in_op;
  logic [DATA_W-1:0]  in_data;
  logic [CNT_W-1:0]   in_count;
  logic               in_xfer;
  logic               slot_free;

  // Emission
  logic               emit;
  logic [DATA_W-1:0]  e_data;
  status_t            e_status;
  logic               e_last;
  logic [CNT_W-1:0]   e_done;

  // RAM port
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  // Helpers
  logic [CNT_W-1:0]   cfg_cap;
  logic [BURST_W-1:0] req_burst;
  logic [CNT_W-1:0]   del_n;
  logic [CNT_W:0]     del_sum;
  logic [ADDR_W-1:0]  del_head;
  logic [ADDR_W-1:0]  pos_adv;
  logic               avail;
  logic               burst_end;

  assign in_op    = op_t'(in_tuser);
  assign in_data  = in_tdata[DATA_W-1:0];
  assign in_count = in_tdata[DATA_W +: CNT_W];

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_xfer   = in_tvalid && in_tready;

  // Clamp the written capacity into 1..DEPTH.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(DEPTH)) begin
      cfg_cap = CNT_W'(DEPTH);
    end else begin
      cfg_cap = cfg_wr_data;
    end
  end

  // Saturate the pop/peek count at the burst limit.
  assign req_burst = (in_count < CNT_W'(MAX_BURST)) ? BURST_W'(in_count)
                                                    : BURST_W'(MAX_BURST);

  // Delete: drop min(count, level); head moves forward with one wrap at most.
  assign del_n    = (in_count < level_r) ? in_count : level_r;
  assign del_sum  = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(del_n);
  assign del_head = (del_sum >= {1'b0, cap_r}) ? ADDR_W'(del_sum - {1'b0, cap_r})
                                               : ADDR_W'(del_sum);

  // Burst bookkeeping: pop checks what is left, peek checks the offset.
  assign pos_adv   = ring_adv(pos_r, cap_r);
  assign avail     = pop_r ? (level_r != '0) : (CNT_W'(idx_r) < level_r);
  assign burst_end = (idx_r + BURST_W'(1)) == nburst_r;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    level_nxt  = level_r;
    cap_nxt    = cap_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    nburst_nxt = nburst_r;
    pop_nxt    = pop_r;
    emit       = 1'b0;
    e_data     = '0;
    e_status   = ST_OK;
    e_last     = 1'b1;
    e_done     = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = head_r;

    if (cfg_wr_en) begin
      // Any capacity write empties the buffer.
      cap_nxt   = cfg_cap;
      head_nxt  = '0;
      tail_nxt  = '0;
      level_nxt = '0;
      state_nxt = S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_op)
              OP_PUSH: begin
                emit = 1'b1;
                if (level_r >= cap_r) begin
                  e_status = ST_FULL;
                end else begin
                  ram_we    = 1'b1;
                  tail_nxt  = ring_adv(tail_r, cap_r);
                  level_nxt = level_r + CNT_W'(1);
                  e_done    = CNT_W'(1);
                end
              end
              OP_DELETE: begin
                emit      = 1'b1;
                head_nxt  = del_head;
                level_nxt = level_r - del_n;
                e_done    = del_n;
                e_status  = (del_n < in_count) ? ST_EMPTY : ST_OK;
              end
              OP_POP, OP_PEEK: begin
                if (req_burst == '0) begin
                  emit = 1'b1;
                end else begin
                  // Issue the first read now; data is ready in the burst state.
                  ram_re     = 1'b1;
                  ram_raddr  = head_r;
                  pos_nxt    = head_r;
                  idx_nxt    = '0;
                  nburst_nxt = req_burst;
                  pop_nxt    = (in_op == OP_POP);
                  state_nxt  = S_BURST;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_BURST: begin
          if (slot_free) begin
            emit = 1'b1;
            if (!avail) begin
              // Ran out of words: close the run short.
              e_status  = ST_EMPTY;
              e_done    = CNT_W'(idx_r);
              state_nxt = S_IDLE;
            end else begin
              e_data  = ram_rdata;
              e_last  = burst_end;
              e_done  = CNT_W'(idx_r) + CNT_W'(1);
              idx_nxt = idx_r + BURST_W'(1);
              pos_nxt = pos_adv;
              if (pop_r) begin
                head_nxt  = pos_adv;
                level_nxt = level_r - CNT_W'(1);
              end
              if (burst_end) begin
                state_nxt = S_IDLE;
              end else begin
                // Fetch the next word while this one goes out.
                ram_re    = 1'b1;
                ram_raddr = pos_adv;
              end
            end
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      level_r     <= '0;
      cap_r       <= CNT_W'(DEPTH);
      pos_r       <= '0;
      idx_r       <= '0;
      nburst_r    <= '0;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      level_r  <= level_nxt;
      cap_r    <= cap_nxt;
      pos_r    <= pos_nxt;
      idx_r    <= idx_nxt;
      nburst_r <= nburst_nxt;
      pop_r    <= pop_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the output register on every emission; hold it otherwise.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r   <= e_data;
      out_status_r <= e_status;
      out_last_r   <= e_last;
      out_done_r   <= e_done;
      out_fill_r   <= level_nxt;
      out_free_r   <= cap_r - level_nxt;
    end
  end

  rbf_ram #(
    .Depth (DEPTH),
    .Width (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_free_r, out_fill_r, out_done_r, out_data_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

/* design/rbf_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read data holds while no read is enabled. No dependencies.
module rbf_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* test/tb_ring_buffer_fifo_core.sv */
// Self-checking testbench for ring_buffer_fifo_core: directed table, then random phases.
// Depends on rbf_pkg (sizes, opcodes, status codes) and the core RTL only.
// A shadow FIFO predicts every result; a monitor checks each output transfer in order.
module tb_ring_buffer_fifo_core;
  import rbf_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int DIR_ROWS      = 26;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 47;
  localparam int SETTLE_CYCLES = 20;

  // One result as the monitor sees it.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic              last;
    logic [CNT_W-1:0]  done;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  free;
  } fifo_result_t;

  // One directed row: either a capacity write (value in cnt) or an operation.
  // Rows marked typed carry their single expected result written out by hand.
  typedef struct packed {
    logic              is_cfg;
    op_t               op;
    logic [DATA_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
    logic              typed;
    fifo_result_t      res;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CNT_W-1:0]    cfg_wr_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [47:0]         in_tdata;   // [31:0] data_in, [42:32] count, rest zero
  logic [OP_W-1:0]     in_tuser;   // [1:0] opcode
  logic                out_tvalid;
  logic                out_tready;
  logic [71:0]         out_tdata;  // [31:0] data_out, [42:32] done_count,
                                   // [53:43] fill_level, [64:54] free_space
  logic [STATUS_W-1:0] out_tuser;  // [1:0] status
  logic                out_tlast;

  // Shadow copy of the FIFO: storage, pointers, level and capacity in use.
  logic [DATA_W-1:0] shadow_mem [DEPTH];
  int unsigned       shadow_head;
  int unsigned       shadow_tail;
  int unsigned       shadow_level;
  int unsigned       shadow_cap;

  fifo_result_t expected_results [$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  burst_left;
  // results queued by the most recent prediction
  int unsigned  op_results;

  dir_row_t dir_table [DIR_ROWS] = '{
    // empty buffer after reset: reads with a nonzero count come back empty
    '{1'b0, OP_POP,    32'h0,        11'd1,    1'b1,
      '{32'h0, ST_EMPTY, 1'b1, 11'd0, 11'd0, 11'd1024}},
    '{1'b0, OP_PEEK,   32'h0,        11'd0,    1'b1,
      '{32'h0, ST_OK,    1'b1, 11'd0, 11'd0, 11'd1024}},
    '{1'b0, OP_DELETE, 32'h0,        11'd5,    1'b1,
      '{32'h0, ST_EMPTY, 1'b1, 11'd0, 11'd0, 11'd1024}},
    '{1'b0, OP_POP,    32'h0,        11'd0,    1'b1,
      '{32'h0, ST_OK,    1'b1, 11'd0, 11'd0, 11'd1024}},
    // data extremes
    '{1'b0, OP_PUSH,   32'hFFFFFFFF, 11'd0,    1'b1,
      '{32'h0, ST_OK,    1'b1, 11'd1, 11'd1, 11'd1023}},
    '{1'b0, OP_PUSH,   32'h00000000, 11'd0,    1'b1,
      '{32'h0, ST_OK,    1'b1, 11'd1, 11'd2, 11'd1022}},
    '{1'b0, OP_PUSH,   32'hA5A55A5A, 11'd0,    1'b0, '0},
    '{1'b0, OP_PUSH,   32'h5A5AA5A5, 11'd0,    1'b0, '0},
    // peek past the level and past the burst limit, then a short peek
    '{1'b0, OP_PEEK,   32'h0,        11'd1024, 1'b0, '0},
    '{1'b0, OP_PEEK,   32'h0,        11'd3,    1'b0, '0},
    // pop one, then a saturated pop that runs dry
    '{1'b0, OP_POP,    32'h0,        11'd1,    1'b0, '0},
    '{1'b0, OP_POP,    32'h0,        11'd1024, 1'b0, '0},
    '{1'b0, OP_PUSH,   32'h00000001, 11'd0,    1'b0, '0},
    '{1'b0, OP_PUSH,   32'h80000000, 11'd0,    1'b0, '0},
    '{1'b0, OP_PUSH,   32'h7FFFFFFF, 11'd0,    1'b0, '0},
    // bulk delete beyond the burst limit, short by the missing words
    '{1'b0, OP_DELETE, 32'h0,        11'd1024, 1'b1,
      '{32'h0, ST_EMPTY, 1'b1, 11'd3, 11'd0, 11'd1024}},
    // capacity zero is taken as one: second push reports full
    '{1'b1, OP_PUSH,   32'h0,        11'd0,    1'b0, '0},
    '{1'b0, OP_PUSH,   32'hDEADBEEF, 11'd0,    1'b1,
      '{32'h0, ST_OK,    1'b1, 11'd1, 11'd1, 11'd0}},
    '{1'b0, OP_PUSH,   32'h00000000, 11'd0,    1'b1,
      '{32'h0, ST_FULL,  1'b1, 11'd0, 11'd1, 11'd0}},
    '{1'b0, OP_PEEK,   32'h0,        11'd2,    1'b0, '0},
    '{1'b0, OP_DELETE, 32'h0,        11'd1,    1'b1,
      '{32'h0, ST_OK,    1'b1, 11'd1, 11'd0, 11'd1}},
    // capacity above the depth is taken as the depth
    '{1'b1, OP_PUSH,   32'h0,        11'd2047, 1'b0, '0},
    '{1'b0, OP_PUSH,   32'hC0FFEE00, 11'd0,    1'b0, '0},
    '{1'b0, OP_PEEK,   32'h0,        11'd16,   1'b0, '0},
    '{1'b0, OP_DELETE, 32'h0,        11'd0,    1'b1,
      '{32'h0, ST_OK,    1'b1, 11'd0, 11'd1, 11'd1023}},
    '{1'b0, OP_DELETE, 32'h0,        11'd2,    1'b1,
      '{32'h0, ST_EMPTY, 1'b1, 11'd1, 11'd0, 11'd1024}}
  };

  ring_buffer_fifo_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Step a shadow ring index, wrapping at the capacity in use.
  function automatic int unsigned ring_next(int unsigned pos);
    return (pos + 1 >= shadow_cap) ? 0 : pos + 1;
  endfunction

  // Queue one expected result; level and free space are taken after the result.
  function automatic void queue_result(logic [DATA_W-1:0] data, status_t st, logic last,
                                       int unsigned done);
    fifo_result_t r;
    r.data   = data;
    r.status = st;
    r.last   = last;
    r.done   = CNT_W'(done);
    r.fill   = CNT_W'(shadow_level);
    r.free   = CNT_W'(shadow_cap - shadow_level);
    expected_results.push_back(r);
    op_results++;
  endfunction

  // Apply one operation to the shadow FIFO and queue every result it causes.
  function automatic void fifo_predict(op_t op, logic [DATA_W-1:0] word,
                                       logic [CNT_W-1:0] cnt);
    int unsigned n;
    int unsigned pos;
    logic [DATA_W-1:0] d;
    op_results = 0;
    case (op)
      OP_PUSH: begin
        if (shadow_level >= shadow_cap) begin
          queue_result('0, ST_FULL, 1'b1, 0);
        end else begin
          shadow_mem[shadow_tail] = word;
          shadow_tail = ring_next(shadow_tail);
          shadow_level++;
          queue_result('0, ST_OK, 1'b1, 1);
        end
      end
      OP_DELETE: begin
        // Bulk delete is not bounded by the burst limit.
        n = (cnt < shadow_level) ? cnt : shadow_level;
        for (int unsigned i = 0; i < n; i++) shadow_head = ring_next(shadow_head);
        shadow_level -= n;
        queue_result('0, (n < cnt) ? ST_EMPTY : ST_OK, 1'b1, n);
      end
      default: begin
        // Pop and peek: saturate at the burst limit, end short with status empty.
        n = (cnt < MAX_BURST) ? cnt : MAX_BURST;
        if (n == 0) begin
          queue_result('0, ST_OK, 1'b1, 0);
          return;
        end
        pos = shadow_head;
        for (int unsigned i = 0; i < n; i++) begin
          if (op == OP_POP) begin
            if (shadow_level == 0) begin
              queue_result('0, ST_EMPTY, 1'b1, i);
              return;
            end
            d = shadow_mem[shadow_head];
            shadow_head = ring_next(shadow_head);
            shadow_level--;
          end else begin
            if (i >= shadow_level) begin
              queue_result('0, ST_EMPTY, 1'b1, i);
              return;
            end
            d = shadow_mem[pos];
            pos = ring_next(pos);
          end
          queue_result(d, ST_OK, (i + 1 == n), i + 1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Sender pacing: bursts of random length, random gaps between them,
  // now and then a long burst with no gaps at all.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        in_tdata  = 48'({$urandom, $urandom});
        in_tuser  = OP_W'($urandom);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  // Present one operation, hold it until the transfer, then predict its results.
  task automatic send_fifo_op(op_t op, logic [DATA_W-1:0] word, logic [CNT_W-1:0] cnt);
    @(negedge clk);
    in_tdata  = {5'b0, cnt, word};
    in_tuser  = op;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    fifo_predict(op, word, cnt);
  endtask

  // Drain the block, then write the capacity; the shadow FIFO empties too.
  task automatic write_capacity(logic [CNT_W-1:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cfg_wr_data = CNT_W'($urandom);
    if (value == 0) shadow_cap = 1;
    else if (value > DEPTH) shadow_cap = DEPTH;
    else shadow_cap = 32'(value);
    shadow_head  = 0;
    shadow_tail  = 0;
    shadow_level = 0;
    burst_left   = 0;
  endtask

  // Receiver: stall on a pattern that changes every stretch of cycles.
  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned ctr;
    int unsigned stall_left;
    out_tready = 1'b0;
    ctr        = 0;
    stall_left = 0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(16, 96);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = 1'($urandom_range(0, 1));
          2: begin
            ctr++;
            out_tready = (ctr % 3 == 0);
          end
          default: begin
            // long stall runs with short ready windows between
            if (stall_left > 0) begin
              out_tready = 1'b0;
              stall_left--;
            end else begin
              out_tready = 1'b1;
              if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
            end
          end
        endcase
      end
    end
  end

  // Monitor: check each output transfer against the oldest expectation.
  always @(posedge clk) begin
    fifo_result_t got;
    fifo_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data   = out_tdata[31:0];
      got.done   = out_tdata[42:32];
      got.fill   = out_tdata[53:43];
      got.free   = out_tdata[64:54];
      got.status = status_t'(out_tuser);
      got.last   = out_tlast;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", got.data, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.data !== want.data)     report_mismatch("data_out", got.data, want.data);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.last !== want.last)     report_mismatch("last", got.last, want.last);
        if (got.done !== want.done)     report_mismatch("done_count", got.done, want.done);
        if (got.fill !== want.fill)     report_mismatch("fill_level", got.fill, want.fill);
        if (got.free !== want.free)     report_mismatch("free_space", got.free, want.free);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_ring_buffer_fifo_core NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned  r;
    op_t          op;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cap_value;
    logic [CNT_W-1:0] phase_caps [PHASES];

    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 0;
    op_results     = 0;
    shadow_head    = 0;
    shadow_tail    = 0;
    shadow_level   = 0;
    shadow_cap     = DEPTH;
    // capacities of the random phases; the last one is drawn at random
    phase_caps = '{11'd3, 11'd1, 11'd17, 11'd2, 11'd1024, 11'd5, 11'd2047, 11'd0, 11'd0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: typed rows replace the predicted result by the one written out.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].is_cfg) begin
        write_capacity(dir_table[i].cnt);
      end else begin
        pace_sender();
        send_fifo_op(dir_table[i].op, dir_table[i].word, dir_table[i].cnt);
        if (dir_table[i].typed) begin
          repeat (op_results) void'(expected_results.pop_back());
          expected_results.push_back(dir_table[i].res);
        end
      end
    end

    // Random phases, one capacity each; pushes dominate so small rings fill and wrap.
    for (int p = 0; p < PHASES; p++) begin
      cap_value = (p == PHASES - 1) ? CNT_W'($urandom_range(1, 64)) : phase_caps[p];
      write_capacity(cap_value);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) op = OP_PUSH;
        else if (r < 65) op = OP_POP;
        else if (r < 85) op = OP_PEEK;
        else op = OP_DELETE;
        r = $urandom_range(0, 9);
        if (r == 0) cnt = '0;
        else if (r == 1) cnt = 11'd1024;
        else if (r == 2) cnt = CNT_W'($urandom_range(17, 1023));
        else cnt = CNT_W'($urandom_range(1, 17));
        pace_sender();
        send_fifo_op(op, $urandom, cnt);
      end
    end

    // Drop valid, drain every expected result, then let the block settle.
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_ring_buffer_fifo_core OK");
    end else begin
      $display("tb_ring_buffer_fifo_core NOT OK");
    end
    $finish;
  end

endmodule
